// ----- src/sppa_pkg.sv -----
// ----------------------------------------------------------------------------
// sppa_pkg: shared definitions for the SRAM page pool allocator
// Field widths, pool geometry, operation and status codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sppa_pkg;

    // Pool geometry
    localparam int PAGE_BYTES = 4096;
    localparam int POOL_PAGES = 64;
    localparam int CLIENTS    = 4;

    localparam int PAGE_OFS_W = $clog2(PAGE_BYTES);
    localparam int PAGE_IDX_W = $clog2(POOL_PAGES);
    localparam int PAGE_CNT_W = $clog2(POOL_PAGES + 1);
    localparam int CLIENT_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int TBL_DEPTH  = CLIENTS * POOL_PAGES;
    localparam int TBL_AW     = CLIENT_W + PAGE_IDX_W;

    // Transaction field widths
    localparam int OP_W           = 2;
    localparam int CLIENT_FIELD_W = 2;
    localparam int SIZE_W         = 19;
    localparam int POS_W          = 18;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 7;
    localparam int OFFSET_W       = 18;

    // Page count requested by a resize, and a compare width that holds it
    localparam int WANT_W = SIZE_W - PAGE_OFS_W + 1;
    localparam int CMP_W  = WANT_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN      = 2'd0,
        OP_RESIZE    = 2'd1,
        OP_RELEASE   = 2'd2,
        OP_TRANSLATE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_RANGE = 2'd2,
        ST_STATE = 2'd3
    } t_status;

    // Kind of memory work one operation needs
    typedef enum logic [2:0] {
        WK_NONE,
        WK_POP,
        WK_PUSH_DN,
        WK_PUSH_UP,
        WK_LOOKUP
    } t_work;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_POP,
        S_PUSH_DN,
        S_PUSH_UP,
        S_LOOKUP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic eval;
        logic pop;
        logic push_dn;
        logic push_up;
        logic lookup;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic  clear_done;
        t_work work;
        logic  last_up;
        logic  last_dn;
    } t_dp_stat;

endpackage

// ----- src/sppa_req_if.sv -----
// ----------------------------------------------------------------------------
// sppa_req_if: request channel of the page pool allocator
// Valid/ready handshake carrying one operation per transaction.
// ----------------------------------------------------------------------------
interface sppa_req_if;
    import sppa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [CLIENT_FIELD_W-1:0] client;
    logic [SIZE_W-1:0]         size_bytes;
    logic [POS_W-1:0]          position;

    modport source (output valid, output op, output client, output size_bytes,
                    output position, input ready);
    modport sink   (input valid, input op, input client, input size_bytes,
                    input position, output ready);
endinterface

// ----- src/sppa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sppa_rsp_if: response channel of the page pool allocator
// Valid/ready handshake carrying one result per transaction.
// ----------------------------------------------------------------------------
interface sppa_rsp_if;
    import sppa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  page_count;
    logic [OFFSET_W-1:0] sram_offset;

    modport source (output valid, output status, output page_count,
                    output sram_offset, input ready);
    modport sink   (input valid, input status, input page_count,
                    input sram_offset, output ready);
endinterface

// ----- src/sram_page_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// sram_page_pool_allocator: LIFO free-list page allocator for a shared SRAM
// Hands out fixed-size SRAM pages to a few clients and translates client
// byte positions to SRAM offsets.
// ----------------------------------------------------------------------------
// Usage and sequencing: after reset the block loads the free stack with
// pages 0..63 and holds i_req.ready low until that pass is done. It then
// takes one operation at a time. Each operation is accepted, evaluated and
// ends in the step that loads the result register; an operation that moves
// no page (errors, resize to the same size, release of an empty client)
// does nothing else, open and translate also do one RAM read, and resize or
// release do one read per page moved, since every page moved costs one read
// of the stack or page-table RAM. The result-loading step waits while an
// earlier response is still stalled. Each operation yields exactly one
// response transaction; the result sits in an output register, so a new
// request is taken while the previous response still waits for o_rsp.ready.
module sram_page_pool_allocator import sppa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sppa_req_if.sink          i_req,
    sppa_rsp_if.source        o_rsp
);
    // Command and status between sequencer and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: walks clear, evaluate, page moves and result hand-off
    sppa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: free stack RAM, page table RAM, per-client counts and flags
    sppa_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_req.op),
        .i_client      (i_req.client),
        .i_size_bytes  (i_req.size_bytes),
        .i_position    (i_req.position),
        .o_status      (o_rsp.status),
        .o_page_count  (o_rsp.page_count),
        .o_sram_offset (o_rsp.sram_offset)
    );
endmodule

// ----- src/sppa_ram.sv -----
// ----------------------------------------------------------------------------
// sppa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module sppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/sppa_ctrl.sv -----
// ----------------------------------------------------------------------------
// sppa_ctrl: allocator sequencer
// Walks each operation through evaluate, page moves and result hand-off,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module sppa_ctrl import sppa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_stat.clear_done) n_state = S_IDLE;
            S_IDLE:    if (i_in_valid) n_state = S_EVAL;
            S_EVAL: begin
                unique case (i_stat.work)
                    WK_POP:     n_state = S_POP;
                    WK_PUSH_DN: n_state = S_PUSH_DN;
                    WK_PUSH_UP: n_state = S_PUSH_UP;
                    WK_LOOKUP:  n_state = S_LOOKUP;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_POP:     if (i_stat.last_up) n_state = S_FINISH;
            S_PUSH_UP: if (i_stat.last_up) n_state = S_FINISH;
            S_PUSH_DN: if (i_stat.last_dn) n_state = S_FINISH;
            S_LOOKUP:  n_state = S_FINISH;
            S_FINISH:  if (out_free) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_CLEAR:   o_cmd.clear   = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EVAL:    o_cmd.eval    = 1'b1;
            S_POP:     o_cmd.pop     = 1'b1;
            S_PUSH_DN: o_cmd.push_dn = 1'b1;
            S_PUSH_UP: o_cmd.push_up = 1'b1;
            S_LOOKUP:  o_cmd.lookup  = 1'b1;
            S_FINISH:  o_cmd.finish  = out_free;
            default:   o_cmd         = '0;
        endcase
    end

    // Hold the result until the sink takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- src/sppa_datapath.sv -----
// ----------------------------------------------------------------------------
// sppa_datapath: free stack, page tables and client bookkeeping
// Evaluates an operation, moves one page per cycle between the free stack
// and a page table, and forms the result.
// ----------------------------------------------------------------------------
module sppa_datapath import sppa_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [OP_W-1:0]           i_op,
    input  logic [CLIENT_FIELD_W-1:0] i_client,
    input  logic [SIZE_W-1:0]         i_size_bytes,
    input  logic [POS_W-1:0]          i_position,
    output logic [STATUS_W-1:0]       o_status,
    output logic [COUNT_W-1:0]        o_page_count,
    output logic [OFFSET_W-1:0]       o_sram_offset
);
    // Latched transaction
    t_op                       r_op;
    logic [CLIENT_FIELD_W-1:0] r_client;
    logic [WANT_W-1:0]         r_want;
    logic [POS_W-1:0]          r_pos;
    logic [WANT_W-1:0]         n_want;

    // Pool state
    logic [PAGE_CNT_W-1:0] r_free_count;
    logic [PAGE_CNT_W-1:0] r_client_pages [CLIENTS];
    logic [CLIENTS-1:0]    r_client_open;
    logic [PAGE_IDX_W-1:0] r_clr;

    // Operation plan
    logic [PAGE_CNT_W-1:0] r_idx, r_end, r_new_pages;
    logic                  r_new_open, r_upd, r_xlate;
    t_status               r_status;

    // Page move in flight: memory write in the cycle after the read
    logic                  r_pend_pop, r_pend_push;
    logic [TBL_AW-1:0]     r_pend_taddr;
    logic [PAGE_IDX_W-1:0] r_pend_saddr;

    // Result register
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;
    logic [OFFSET_W-1:0] r_out_offset;

    // Evaluation
    logic [CLIENT_W-1:0]   ci;
    logic                  client_ok;
    logic [PAGE_CNT_W-1:0] have;
    logic                  is_open;
    logic [CMP_W-1:0]      want_x, have_x, fc_x, pidx_x;
    t_status               e_status;
    t_work                 e_work;
    logic [PAGE_CNT_W-1:0] e_idx, e_end, e_new_pages;
    logic                  e_new_open, e_upd, e_xlate;

    logic [PAGE_CNT_W-1:0] idx_m1, fc_m1;
    logic [TBL_AW-1:0]     tbl_raddr;
    logic [PAGE_IDX_W-1:0] stk_rdata, tbl_rdata;

    assign ci        = r_client[CLIENT_W-1:0];
    assign client_ok = 32'(r_client) < CLIENTS;
    assign have      = r_client_pages[ci];
    assign is_open   = r_client_open[ci];
    assign want_x    = CMP_W'(r_want);
    assign have_x    = CMP_W'(have);
    assign fc_x      = CMP_W'(r_free_count);
    assign pidx_x    = CMP_W'(r_pos[POS_W-1:PAGE_OFS_W]);
    assign idx_m1    = r_idx - 1'b1;
    assign fc_m1     = r_free_count - 1'b1;

    // Round the byte count up to whole pages
    assign n_want = WANT_W'(({1'b0, i_size_bytes} + (SIZE_W + 1)'(PAGE_BYTES - 1))
                            >> PAGE_OFS_W);

    always_comb begin
        e_status    = ST_OK;
        e_work      = WK_NONE;
        e_idx       = '0;
        e_end       = '0;
        e_new_pages = have;
        e_new_open  = is_open;
        e_upd       = 1'b0;
        e_xlate     = 1'b0;
        if (!client_ok) begin
            e_status = ST_STATE;
        end else if (r_op == OP_OPEN) begin
            if (is_open) begin
                e_status = ST_STATE;
            end else if (r_free_count == '0) begin
                e_status = ST_NOMEM;
            end else begin
                e_work      = WK_POP;
                e_end       = PAGE_CNT_W'(1);
                e_new_pages = PAGE_CNT_W'(1);
                e_new_open  = 1'b1;
                e_upd       = 1'b1;
            end
        end else if (!is_open) begin
            e_status = ST_STATE;
        end else begin
            case (r_op)
                OP_RESIZE: begin
                    if (want_x > have_x) begin
                        if ((want_x - have_x) > fc_x) begin
                            e_status = ST_NOMEM;
                        end else begin
                            e_work      = WK_POP;
                            e_idx       = have;
                            e_end       = PAGE_CNT_W'(r_want);
                            e_new_pages = PAGE_CNT_W'(r_want);
                            e_upd       = 1'b1;
                        end
                    end else begin
                        e_work      = (want_x < have_x) ? WK_PUSH_DN : WK_NONE;
                        e_idx       = have;
                        e_end       = PAGE_CNT_W'(r_want);
                        e_new_pages = PAGE_CNT_W'(r_want);
                        e_upd       = 1'b1;
                    end
                end
                OP_RELEASE: begin
                    e_work      = (have != '0) ? WK_PUSH_UP : WK_NONE;
                    e_end       = have;
                    e_new_pages = '0;
                    e_new_open  = 1'b0;
                    e_upd       = 1'b1;
                end
                default: begin
                    if (pidx_x >= have_x) begin
                        e_status = ST_RANGE;
                    end else begin
                        e_work  = WK_LOOKUP;
                        e_xlate = 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_stat.clear_done = r_clr == PAGE_IDX_W'(POOL_PAGES - 1);
    assign o_stat.work       = e_work;
    assign o_stat.last_up    = (r_idx + 1'b1) == r_end;
    assign o_stat.last_dn    = idx_m1 == r_end;

    always_comb begin
        if (i_cmd.push_dn) begin
            tbl_raddr = {ci, idx_m1[PAGE_IDX_W-1:0]};
        end else if (i_cmd.push_up) begin
            tbl_raddr = {ci, r_idx[PAGE_IDX_W-1:0]};
        end else begin
            tbl_raddr = {ci, r_pos[PAGE_OFS_W +: PAGE_IDX_W]};
        end
    end

    sppa_ram #(.WIDTH(PAGE_IDX_W), .DEPTH(POOL_PAGES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear || r_pend_push),
        .i_waddr (i_cmd.clear ? r_clr : r_pend_saddr),
        .i_wdata (i_cmd.clear ? r_clr : tbl_rdata),
        .i_re    (i_cmd.pop),
        .i_raddr (fc_m1[PAGE_IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    sppa_ram #(.WIDTH(PAGE_IDX_W), .DEPTH(TBL_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (r_pend_pop),
        .i_waddr (r_pend_taddr),
        .i_wdata (stk_rdata),
        .i_re    (i_cmd.push_dn || i_cmd.push_up || i_cmd.lookup),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count  <= PAGE_CNT_W'(POOL_PAGES);
            r_client_open <= '0;
            r_clr         <= '0;
            r_pend_pop    <= 1'b0;
            r_pend_push   <= 1'b0;
            for (int k = 0; k < CLIENTS; k++) begin
                r_client_pages[k] <= '0;
            end
        end else begin
            r_pend_pop  <= i_cmd.pop;
            r_pend_push <= i_cmd.push_dn || i_cmd.push_up;
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.pop) begin
                r_free_count <= fc_m1;
            end else if (i_cmd.push_dn || i_cmd.push_up) begin
                r_free_count <= r_free_count + 1'b1;
            end
            if (i_cmd.finish && r_upd) begin
                r_client_pages[ci] <= r_new_pages;
                r_client_open[ci]  <= r_new_open;
            end
        end
    end

    // Payload and plan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= t_op'(i_op);
            r_client <= i_client;
            r_want   <= n_want;
            r_pos    <= i_position;
        end
        if (i_cmd.eval) begin
            r_status    <= e_status;
            r_idx       <= e_idx;
            r_end       <= e_end;
            r_new_pages <= e_new_pages;
            r_new_open  <= e_new_open;
            r_upd       <= e_upd;
            r_xlate     <= e_xlate;
        end else if (i_cmd.pop || i_cmd.push_up) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.push_dn) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.pop) begin
            r_pend_taddr <= {ci, r_idx[PAGE_IDX_W-1:0]};
        end
        if (i_cmd.push_dn || i_cmd.push_up) begin
            r_pend_saddr <= r_free_count[PAGE_IDX_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_count  <= !client_ok ? '0 :
                            COUNT_W'(r_upd ? r_new_pages : have);
            r_out_offset <= r_xlate ? OFFSET_W'({tbl_rdata, r_pos[PAGE_OFS_W-1:0]}) : '0;
        end
    end

    assign o_status      = r_out_status;
    assign o_page_count  = r_out_count;
    assign o_sram_offset = r_out_offset;
endmodule

// ----- src/sppa_checker.sv -----
// ----------------------------------------------------------------------------
// sppa_checker: port-level checks for the page pool allocator
// Watches both channels of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module sppa_checker import sppa_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_rsp_status,
    input logic [COUNT_W-1:0]  i_rsp_page_count,
    input logic [OFFSET_W-1:0] i_rsp_sram_offset
);
    // One operation at a time: no request right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while an operation is in flight");

    // No offset comes with a failed response
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> i_rsp_sram_offset == '0)
        else $error("nonzero offset on a failed response");

    // A client can never own more than the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_rsp_page_count) <= POOL_PAGES)
        else $error("page count beyond pool size");

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_page_count) && $stable(i_rsp_sram_offset))
        else $error("stalled response changed");
endmodule

bind sram_page_pool_allocator sppa_checker u_sppa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_page_count  (o_rsp.page_count),
    .i_rsp_sram_offset (o_rsp.sram_offset)
);

// ----- test/sppa_result_checker.sv -----
// ----------------------------------------------------------------------------
// sppa_result_checker: scoreboard for the SRAM page pool allocator
// Watches both channels, keeps its own copy of the free stack, page tables
// and client states, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module sppa_result_checker import sppa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sppa_req_if  i_req,
    sppa_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  page_count;
        logic [OFFSET_W-1:0] sram_offset;
    } t_result;

    logic [PAGE_IDX_W-1:0] free_pages [POOL_PAGES];
    logic [PAGE_CNT_W-1:0] free_total;
    logic [PAGE_IDX_W-1:0] page_map   [CLIENTS][POOL_PAGES];
    logic [PAGE_CNT_W-1:0] owned      [CLIENTS];
    logic                  is_open    [CLIENTS];
    t_result               due_results [$];
    int                    errors = 0;

    function automatic void return_page(logic [PAGE_IDX_W-1:0] pg);
        if (free_total < POOL_PAGES) begin
            free_pages[free_total[PAGE_IDX_W-1:0]] = pg;
            free_total = free_total + 1'b1;
        end
    endfunction

    function automatic logic [PAGE_IDX_W-1:0] take_page();
        if (free_total == 0)
            return '0;
        free_total = free_total - 1'b1;
        return free_pages[free_total[PAGE_IDX_W-1:0]];
    endfunction

    // Apply one operation to the pool copy and return the response it gives.
    function automatic t_result apply_pool_op(t_op op, int c, int size, int pos);
        t_result r;
        int      want;
        int      have;
        int      i;
        r.status      = ST_OK;
        r.page_count  = '0;
        r.sram_offset = '0;
        if (op == OP_OPEN) begin
            if (is_open[c]) begin
                r.status = ST_STATE;
            end else if (free_total == 0) begin
                r.status = ST_NOMEM;
            end else begin
                page_map[c][0] = take_page();
                owned[c]       = PAGE_CNT_W'(1);
                is_open[c]     = 1'b1;
            end
        end else if (!is_open[c]) begin
            r.status = ST_STATE;
        end else begin
            case (op)
                OP_RESIZE: begin
                    want = (size + PAGE_BYTES - 1) / PAGE_BYTES;
                    have = int'(owned[c]);
                    if (want > have) begin
                        // Failed growth leaves stack and count untouched
                        if (want - have > int'(free_total)) begin
                            r.status = ST_NOMEM;
                        end else begin
                            for (i = have; i < want; i++)
                                page_map[c][i] = take_page();
                            owned[c] = PAGE_CNT_W'(want);
                        end
                    end else begin
                        for (i = have; i > want; i--)
                            return_page(page_map[c][i-1]);
                        owned[c] = PAGE_CNT_W'(want);
                    end
                end
                OP_RELEASE: begin
                    for (i = 0; i < owned[c]; i++)
                        return_page(page_map[c][i]);
                    owned[c]   = '0;
                    is_open[c] = 1'b0;
                end
                default: begin
                    if (pos >= int'(owned[c]) * PAGE_BYTES)
                        r.status = ST_RANGE;
                    else
                        r.sram_offset = OFFSET_W'(page_map[c][pos / PAGE_BYTES] * PAGE_BYTES
                                                  + pos % PAGE_BYTES);
                end
            endcase
        end
        r.page_count = owned[c];
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            for (int p = 0; p < POOL_PAGES; p++)
                free_pages[p] = p[PAGE_IDX_W-1:0];
            free_total = PAGE_CNT_W'(POOL_PAGES);
            for (int c = 0; c < CLIENTS; c++) begin
                owned[c]   = '0;
                is_open[c] = 1'b0;
            end
            due_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                due_results.push_back(apply_pool_op(t_op'(i_req.op), int'(i_req.client),
                                                    int'(i_req.size_bytes),
                                                    int'(i_req.position)));
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                             $time, i_rsp.status, i_rsp.page_count, i_rsp.sram_offset);
                    errors++;
                end else begin
                    exp_r = due_results.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(i_rsp.status));
                    check_field("page_count", 32'(exp_r.page_count),
                                32'(i_rsp.page_count));
                    check_field("sram_offset", 32'(exp_r.sram_offset),
                                32'(i_rsp.sram_offset));
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= errors;
    end

endmodule

// ----- test/sram_page_pool_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// sram_page_pool_allocator_tb: stimulus and verdict for the page pool allocator
// Drives a directed walk through the error and boundary cases, then random
// open/resize/release/translate traffic under three idle patterns; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module sram_page_pool_allocator_tb;
    import sppa_pkg::*;

    localparam int RANDOM_OPS = 1800;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   results_due;
    int   src_gap_pct;
    int   snk_gap_pct;

    sppa_req_if req_ch ();
    sppa_rsp_if rsp_ch ();

    sram_page_pool_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sppa_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_due)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the response channel at the rate of the current phase.
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_gap_pct);
    end

    // Offer one operation, idling first at the sender rate, and hold it
    // until the block takes the transaction. Return just after that edge.
    task automatic issue_op(t_op op, logic [CLIENT_FIELD_W-1:0] client,
                            logic [SIZE_W-1:0] size_bytes, logic [POS_W-1:0] position);
        while ($urandom_range(99) < src_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.client     <= client;
        req_ch.size_bytes <= size_bytes;
        req_ch.position   <= position;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding response has come back.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    initial begin
        int                       p;
        t_op                      op;
        logic [CLIENT_FIELD_W-1:0] cl;
        logic [SIZE_W-1:0]        sz;
        logic [POS_W-1:0]         pos;

        // Phase one: sender idles rarely, receiver stalls most of the time
        src_gap_pct        = 21;
        snk_gap_pct        = 77;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_OPEN;
        req_ch.client     <= '0;
        req_ch.size_bytes <= '0;
        req_ch.position   <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk: closed-client errors, open, page edges of translate,
        // resize to same, grow, zero and oversize, pool exhaustion, release.
        issue_op(OP_TRANSLATE, 2'd0, '0, '0);
        issue_op(OP_RESIZE,    2'd1, SIZE_W'(PAGE_BYTES), '0);
        issue_op(OP_RELEASE,   2'd2, '0, '0);
        issue_op(OP_OPEN,      2'd0, '0, '0);
        issue_op(OP_OPEN,      2'd0, '0, '0);
        issue_op(OP_TRANSLATE, 2'd0, '0, '0);
        issue_op(OP_TRANSLATE, 2'd0, '0, POS_W'(PAGE_BYTES - 1));
        issue_op(OP_TRANSLATE, 2'd0, '0, POS_W'(PAGE_BYTES));
        issue_op(OP_RESIZE,    2'd0, SIZE_W'(1), '0);
        issue_op(OP_RESIZE,    2'd0, SIZE_W'(PAGE_BYTES + 1), '0);
        issue_op(OP_RESIZE,    2'd0, '0, '0);
        issue_op(OP_TRANSLATE, 2'd0, '0, '0);
        issue_op(OP_RESIZE,    2'd0, '1, '0);
        issue_op(OP_RESIZE,    2'd0, SIZE_W'(POOL_PAGES * PAGE_BYTES), '0);
        issue_op(OP_OPEN,      2'd1, '0, '0);
        issue_op(OP_TRANSLATE, 2'd1, '0, '0);
        issue_op(OP_TRANSLATE, 2'd0, '0, '1);
        issue_op(OP_RESIZE,    2'd0, SIZE_W'((POOL_PAGES - 4) * PAGE_BYTES), '0);
        issue_op(OP_OPEN,      2'd3, '0, '0);
        issue_op(OP_RESIZE,    2'd3, SIZE_W'(5 * PAGE_BYTES), '1);
        issue_op(OP_RELEASE,   2'd0, '0, '0);
        issue_op(OP_RELEASE,   2'd0, '0, '0);
        issue_op(OP_RELEASE,   2'd3, '0, '0);
        issue_op(OP_OPEN,      2'd2, '0, '0);

        // Let the pool settle before random traffic
        hold_until_drained();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            // Swap idle pattern at each third, draining first
            if (n == RANDOM_OPS / 3) begin
                hold_until_drained();
                src_gap_pct <= 77;
                snk_gap_pct <= 21;
            end else if (n == 2 * RANDOM_OPS / 3) begin
                hold_until_drained();
                src_gap_pct <= 0;
                snk_gap_pct <= 0;
            end

            p = $urandom_range(99);
            if (p < 20)
                op = OP_OPEN;
            else if (p < 60)
                op = OP_RESIZE;
            else if (p < 70)
                op = OP_RELEASE;
            else
                op = OP_TRANSLATE;
            cl = CLIENT_FIELD_W'($urandom_range(CLIENTS - 1));

            // Keep most sizes to a few pages so four clients share the pool;
            // hit page edges often and the full field now and then.
            p = $urandom_range(99);
            if (p < 5)
                sz = '0;
            else if (p < 10)
                sz = SIZE_W'($urandom);
            else if (p < 30)
                sz = SIZE_W'($urandom_range(16, 1) * PAGE_BYTES + $urandom_range(2) - 1);
            else
                sz = SIZE_W'($urandom_range(16 * PAGE_BYTES, 1));

            if ($urandom_range(99) < 60)
                pos = POS_W'($urandom_range(16 * PAGE_BYTES - 1));
            else
                pos = POS_W'($urandom);

            issue_op(op, cl, sz, pos);
        end

        // Wait out the last responses plus the block's worst operation time
        hold_until_drained();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Abort a hung run
    initial begin
        #3_200_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
